>>> design/mtcqf_pkg.sv
// ----------------------------------------------------------------------------
// mtcqf_pkg
// Types, codes and helpers shared by the time code quarter-frame tracker.
// ----------------------------------------------------------------------------
package mtcqf_pkg;

   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 72;

   localparam logic [7:0] FULL_FRAME_LENGTH = 8'd10;
   localparam logic [7:0] UNIVERSAL_RT_ID   = 8'h7F;
   localparam logic [7:0] SUB_ID_MTC        = 8'h01;
   localparam logic [7:0] SUB_ID_FULL_FRAME = 8'h01;
   localparam logic [3:0] COUNT_FULL        = 4'd8;

   localparam logic [2:0] PIECE_FRAMES_LO  = 3'd0;
   localparam logic [2:0] PIECE_FRAMES_HI  = 3'd1;
   localparam logic [2:0] PIECE_SECONDS_LO = 3'd2;
   localparam logic [2:0] PIECE_SECONDS_HI = 3'd3;
   localparam logic [2:0] PIECE_MINUTES_LO = 3'd4;
   localparam logic [2:0] PIECE_MINUTES_HI = 3'd5;
   localparam logic [2:0] PIECE_HOURS_LO   = 3'd6;
   localparam logic [2:0] PIECE_HOURS_HI   = 3'd7;

   localparam logic [1:0] STATUS_STOPPED  = 2'd0;
   localparam logic [1:0] STATUS_FORWARD  = 2'd1;
   localparam logic [1:0] STATUS_BACKWARD = 2'd2;

   typedef enum logic [2:0] {
      RUN_STOPPED  = 3'b001,
      RUN_FORWARD  = 3'b010,
      RUN_BACKWARD = 3'b100
   } run_type;

   typedef struct packed {
      logic        operation;
      logic [6:0]  quarter_byte;
      logic [7:0]  msg_length;
      logic [7:0]  universal_id;
      logic [7:0]  sub_id_one;
      logic [7:0]  sub_id_two;
      logic [6:0]  rate_hours_byte;
      logic [6:0]  minutes_byte;
      logic [6:0]  seconds_byte;
      logic [6:0]  frames_byte;
      logic [31:0] time_stamp;
   } item_type;

   typedef struct packed {
      run_type    run;
      logic [2:0] expected_piece;
      logic [3:0] consecutive_count;
      logic [2:0] first_piece_seen;
      logic [7:0] pending_frames;
      logic [7:0] pending_seconds;
      logic [7:0] pending_minutes;
      logic [4:0] pending_hours;
      logic [1:0] pending_rate;
   } track_type;

   typedef struct packed {
      logic        status_event;
      logic [1:0]  run_status;
      logic        quarter_event;
      logic [2:0]  quarter_index;
      logic        time_event;
      logic        from_full_frame;
      logic [7:0]  frames_out;
      logic [7:0]  seconds_out;
      logic [7:0]  minutes_out;
      logic [4:0]  hours_out;
      logic [1:0]  rate_code;
      logic [31:0] time_stamp_out;
   } result_type;

   localparam track_type TRACK_RESET = '{
      run:               RUN_STOPPED,
      expected_piece:    3'd0,
      consecutive_count: 4'd0,
      first_piece_seen:  3'd0,
      pending_frames:    8'd0,
      pending_seconds:   8'd0,
      pending_minutes:   8'd0,
      pending_hours:     5'd0,
      pending_rate:      2'd0
   };

   function automatic logic [2:0] next_piece(run_type run, logic [2:0] piece,
                                              logic [2:0] expected);
      logic [2:0] nxt;
      case (run)
         RUN_FORWARD: begin
            nxt = piece + 3'd1;
         end
         RUN_BACKWARD: begin
            nxt = piece - 3'd1;
         end
         default: begin
            nxt = expected;
         end
      endcase
      return nxt;
   endfunction

   function automatic logic [1:0] run_code(run_type run);
      logic [1:0] code;
      case (run)
         RUN_FORWARD: begin
            code = STATUS_FORWARD;
         end
         RUN_BACKWARD: begin
            code = STATUS_BACKWARD;
         end
         default: begin
            code = STATUS_STOPPED;
         end
      endcase
      return code;
   endfunction

endpackage

>>> design/mtcqf_step.sv
// ----------------------------------------------------------------------------
// mtcqf_step
// Next tracking state and result for one item, given the current state.
// ----------------------------------------------------------------------------
module mtcqf_step (
   input  mtcqf_pkg::item_type   item,
   input  mtcqf_pkg::track_type  cur,
   input  logic                  skip_tolerated,
   output mtcqf_pkg::track_type  nxt,
   output mtcqf_pkg::result_type res,
   output logic                  has_result
);

   logic [2:0] piece;
   logic [3:0] nib;
   logic       full_ok;
   logic       take;
   logic       closing;

   assign piece = item.quarter_byte[6:4];
   assign nib   = item.quarter_byte[3:0];

   assign full_ok = (item.msg_length == mtcqf_pkg::FULL_FRAME_LENGTH)
                 && (item.universal_id == mtcqf_pkg::UNIVERSAL_RT_ID)
                 && (item.sub_id_one == mtcqf_pkg::SUB_ID_MTC)
                 && (item.sub_id_two == mtcqf_pkg::SUB_ID_FULL_FRAME);

   always_comb begin
      nxt        = cur;
      res        = '0;
      has_result = 1'b0;
      take       = 1'b0;
      closing    = 1'b0;
      res.time_stamp_out = item.time_stamp;

      if (item.operation) begin
         if (full_ok) begin
            nxt                 = mtcqf_pkg::TRACK_RESET;
            has_result          = 1'b1;
            res.status_event    = 1'b1;
            res.time_event      = 1'b1;
            res.from_full_frame = 1'b1;
            res.frames_out      = {1'b0, item.frames_byte};
            res.seconds_out     = {1'b0, item.seconds_byte};
            res.minutes_out     = {1'b0, item.minutes_byte};
            res.hours_out       = item.rate_hours_byte[4:0];
            res.rate_code       = item.rate_hours_byte[6:5];
         end
      end else begin
         if (cur.run == mtcqf_pkg::RUN_STOPPED) begin
            if (cur.consecutive_count == 4'd0) begin
               if ((piece != mtcqf_pkg::PIECE_FRAMES_LO) &&
                   (piece != mtcqf_pkg::PIECE_HOURS_HI)) begin
                  nxt.first_piece_seen  = piece;
                  nxt.consecutive_count = 4'd1;
               end
            end else begin
               take = 1'b1;
               if (cur.consecutive_count == 4'd1) begin
                  res.status_event = 1'b1;
                  if (cur.first_piece_seen < piece) begin
                     nxt.run = mtcqf_pkg::RUN_FORWARD;
                  end else if (cur.first_piece_seen > piece) begin
                     nxt.run = mtcqf_pkg::RUN_BACKWARD;
                  end
               end
               nxt.expected_piece = mtcqf_pkg::next_piece(nxt.run, piece,
                                                          cur.expected_piece);
            end
         end else if (piece != cur.expected_piece) begin
            nxt.consecutive_count = 4'd0;
            if (skip_tolerated) begin
               nxt.expected_piece = mtcqf_pkg::next_piece(cur.run, piece,
                                                          cur.expected_piece);
            end else begin
               nxt              = mtcqf_pkg::TRACK_RESET;
               res.status_event = 1'b1;
               has_result       = 1'b1;
            end
         end else begin
            take = 1'b1;
            if (cur.consecutive_count < mtcqf_pkg::COUNT_FULL) begin
               nxt.consecutive_count = cur.consecutive_count + 4'd1;
            end
         end

         if (take) begin
            case (piece)
               mtcqf_pkg::PIECE_FRAMES_LO: begin
                  nxt.pending_frames = cur.pending_frames | {4'b0, nib};
               end
               mtcqf_pkg::PIECE_FRAMES_HI: begin
                  nxt.pending_frames = cur.pending_frames | {nib, 4'b0};
               end
               mtcqf_pkg::PIECE_SECONDS_LO: begin
                  nxt.pending_seconds = cur.pending_seconds | {4'b0, nib};
               end
               mtcqf_pkg::PIECE_SECONDS_HI: begin
                  nxt.pending_seconds = cur.pending_seconds | {nib, 4'b0};
               end
               mtcqf_pkg::PIECE_MINUTES_LO: begin
                  nxt.pending_minutes = cur.pending_minutes | {4'b0, nib};
               end
               mtcqf_pkg::PIECE_MINUTES_HI: begin
                  nxt.pending_minutes = cur.pending_minutes | {nib, 4'b0};
               end
               mtcqf_pkg::PIECE_HOURS_LO: begin
                  nxt.pending_hours = cur.pending_hours | {1'b0, nib};
               end
               default: begin
                  nxt.pending_hours = cur.pending_hours | {nib[0], 4'b0};
                  nxt.pending_rate  = nib[2:1];
               end
            endcase
            has_result        = 1'b1;
            res.quarter_event = 1'b1;
            res.quarter_index = piece;
            closing = ((nxt.run == mtcqf_pkg::RUN_FORWARD) &&
                       (piece == mtcqf_pkg::PIECE_HOURS_HI))
                   || ((nxt.run == mtcqf_pkg::RUN_BACKWARD) &&
                       (piece == mtcqf_pkg::PIECE_FRAMES_LO));
            if (closing && (nxt.consecutive_count >= mtcqf_pkg::COUNT_FULL)) begin
               res.time_event      = 1'b1;
               res.frames_out      = nxt.pending_frames;
               res.seconds_out     = nxt.pending_seconds;
               res.minutes_out     = nxt.pending_minutes;
               res.hours_out       = nxt.pending_hours;
               res.rate_code       = nxt.pending_rate;
               nxt.pending_frames  = 8'd0;
               nxt.pending_seconds = 8'd0;
               nxt.pending_minutes = 8'd0;
               nxt.pending_hours   = 5'd0;
               nxt.pending_rate    = 2'd0;
            end
            if (nxt.run != mtcqf_pkg::RUN_STOPPED) begin
               nxt.expected_piece = mtcqf_pkg::next_piece(nxt.run, piece,
                                                          cur.expected_piece);
            end
         end
      end

      res.run_status = mtcqf_pkg::run_code(nxt.run);
   end

endmodule

>>> design/midi_timecode_quarter_frame_tracker.sv
// ----------------------------------------------------------------------------
// midi_timecode_quarter_frame_tracker
// Tracks time code quarter frames and full frames, reports time and status.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one item per cycle unless stalled: req_tuser is the operation
//   (0 quarter frame, 1 full-frame candidate), req_tdata the remaining fields.
//   rsp_* returns at most one result per item; items that raise no event
//   (rejected full frames, ignored or skipped pieces) produce nothing.
//   csr_* writes skip_tolerated; write it only while the block is idle.
//   An accepted item is loaded into the input register; its result, if any,
//   is then loaded into the result register, which drives rsp_tvalid.
//   While rsp_tready stays high, one item per cycle passes; the tracking state
//   updates as each item leaves the input register.
//   When rsp_tready is low the result register holds, the input register
//   fills, and then req_tready drops until the result is taken.
//   Reset (synchronous) empties both registers, clears skip_tolerated and
//   puts the tracker in the stopped state with no pending time.
// ----------------------------------------------------------------------------
module midi_timecode_quarter_frame_tracker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [6:0] quarter_byte, [14:7] msg_length, [22:15] universal_id,
   // [30:23] sub_id_one, [38:31] sub_id_two, [45:39] rate_hours_byte,
   // [52:46] minutes_byte, [59:53] seconds_byte, [66:60] frames_byte,
   // [98:67] time_stamp, rest zero
   input  logic [mtcqf_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [0] operation
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [1:0] run_status, [4:2] quarter_index, [12:5] frames_out,
   // [20:13] seconds_out, [28:21] minutes_out, [33:29] hours_out,
   // [35:34] rate_code, [67:36] time_stamp_out, rest zero
   output logic [mtcqf_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // [0] status_event, [1] quarter_event, [2] time_event, [3] from_full_frame
   output logic [3:0]                           rsp_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_data
);

   mtcqf_pkg::item_type   req_item;
   mtcqf_pkg::item_type   in_item_ff;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic                  advance;
   logic                  skip_ff;
   mtcqf_pkg::track_type  track_ff;
   mtcqf_pkg::track_type  track_in;
   mtcqf_pkg::result_type step_res;
   logic                  has_result;
   mtcqf_pkg::result_type rsp_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   assign req_item.operation       = req_tuser;
   assign req_item.quarter_byte    = req_tdata[6:0];
   assign req_item.msg_length      = req_tdata[14:7];
   assign req_item.universal_id    = req_tdata[22:15];
   assign req_item.sub_id_one      = req_tdata[30:23];
   assign req_item.sub_id_two      = req_tdata[38:31];
   assign req_item.rate_hours_byte = req_tdata[45:39];
   assign req_item.minutes_byte    = req_tdata[52:46];
   assign req_item.seconds_byte    = req_tdata[59:53];
   assign req_item.frames_byte     = req_tdata[66:60];
   assign req_item.time_stamp      = req_tdata[98:67];

   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? has_result : (rsp_valid_ff && !rsp_tready);
   assign csr_ready   = 1'b1;

   mtcqf_step u_step (
      .item           (in_item_ff),
      .cur            (track_ff),
      .skip_tolerated (skip_ff),
      .nxt            (track_in),
      .res            (step_res),
      .has_result     (has_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         skip_ff      <= 1'b0;
         track_ff     <= mtcqf_pkg::TRACK_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            skip_ff <= csr_data;
         end
         if (advance) begin
            track_ff <= track_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_item;
      end
      if (advance && has_result) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_ff.time_stamp_out, rsp_ff.rate_code, rsp_ff.hours_out,
                        rsp_ff.minutes_out, rsp_ff.seconds_out, rsp_ff.frames_out,
                        rsp_ff.quarter_index, rsp_ff.run_status};
   assign rsp_tuser  = {rsp_ff.from_full_frame, rsp_ff.time_event,
                        rsp_ff.quarter_event, rsp_ff.status_event};

`ifndef NO_ASSERTIONS
   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      track_ff.consecutive_count <= mtcqf_pkg::COUNT_FULL)
      else $error("consecutive count above saturation");

   a_stopped_count: assert property (@(posedge clock) disable iff (reset)
      (track_ff.run == mtcqf_pkg::RUN_STOPPED) |-> (track_ff.consecutive_count <= 4'd1))
      else $error("stopped tracker with count above one");

   a_full_frame_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.from_full_frame) |->
         (rsp_ff.status_event && rsp_ff.time_event &&
          (rsp_ff.run_status == mtcqf_pkg::STATUS_STOPPED)))
      else $error("full-frame result without stop report");

   a_quarter_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.time_event && !rsp_ff.from_full_frame) |->
         (rsp_ff.quarter_event && (rsp_ff.run_status != mtcqf_pkg::STATUS_STOPPED)))
      else $error("quarter-frame time without running piece");

   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)
                                     && $stable(track_ff)))
      else $error("input register lost an item while stalled");
`endif

endmodule
